>>> hw/rtl/itrt_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants, microcode ROM and digit coding for integer_to_radix_text.
package itrt_pkg;

    localparam int VALUE_W       = 64;
    localparam int RADIX_W       = 6;
    localparam int CHAR_W        = 8;
    localparam int DIGIT_W       = 6;
    localparam int STACK_DEPTH   = 64;
    localparam int IDX_W         = $clog2(STACK_DEPTH);
    localparam int BITS_PER_STEP = 8;
    localparam int STEP_CNT_W    = $clog2(VALUE_W / BITS_PER_STEP);
    localparam int PC_W          = 3;

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
    localparam logic [CHAR_W-1:0]  SIGN_CHAR = 8'h2D;
    localparam logic [CHAR_W-1:0]  ZERO_CHAR = 8'h30;
    localparam logic [CHAR_W-1:0]  UPPER_A   = 8'h41;
    localparam logic [CHAR_W-1:0]  LOWER_A   = 8'h61;
    localparam logic [DIGIT_W-1:0] TEN       = DIGIT_W'(10);

    localparam logic [VALUE_W-1:0] MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic [VALUE_W-1:0] SAT_MAG  = {1'b0, {(VALUE_W-1){1'b1}}};

    // Register map
    localparam logic REG_UPPER_CASE = 1'b0;

    // Microcode step addresses
    localparam logic [PC_W-1:0] STEP_WAIT = PC_W'(0);
    localparam logic [PC_W-1:0] STEP_DIV  = PC_W'(1);
    localparam logic [PC_W-1:0] STEP_PUSH = PC_W'(2);
    localparam logic [PC_W-1:0] STEP_SIGN = PC_W'(3);
    localparam logic [PC_W-1:0] STEP_READ = PC_W'(4);
    localparam logic [PC_W-1:0] STEP_EMIT = PC_W'(5);
    localparam logic [PC_W-1:0] STEP_MORE = PC_W'(6);
    localparam logic [PC_W-1:0] STEP_DONE = PC_W'(7);

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV,
        OP_PUSH,
        OP_SIGN,
        OP_READ,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_DIV_MORE,
        C_QUOT_NZ,
        C_SIGN_WAIT,
        C_OUT_BUSY,
        C_DIGITS_LEFT
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_uword;

    // Strobes from sequencer to datapath
    typedef struct packed {
        logic in_ready;
        logic load;
        logic div;
        logic push;
        logic sign;
        logic read;
        logic emit;
    } t_ctrl;

    // Status from datapath to sequencer
    typedef struct packed {
        logic in_valid;
        logic div_more;
        logic quot_nz;
        logic neg;
        logic out_free;
        logic digits_left;
    } t_stat;

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            STEP_WAIT: w = '{op: OP_LOAD, cond: C_NO_INPUT,    target: STEP_WAIT};
            STEP_DIV:  w = '{op: OP_DIV,  cond: C_DIV_MORE,    target: STEP_DIV};
            STEP_PUSH: w = '{op: OP_PUSH, cond: C_QUOT_NZ,     target: STEP_DIV};
            STEP_SIGN: w = '{op: OP_SIGN, cond: C_SIGN_WAIT,   target: STEP_SIGN};
            STEP_READ: w = '{op: OP_READ, cond: C_NEVER,       target: STEP_WAIT};
            STEP_EMIT: w = '{op: OP_EMIT, cond: C_OUT_BUSY,    target: STEP_EMIT};
            STEP_MORE: w = '{op: OP_NOP,  cond: C_DIGITS_LEFT, target: STEP_READ};
            STEP_DONE: w = '{op: OP_NOP,  cond: C_ALWAYS,      target: STEP_WAIT};
            default:   w = '{op: OP_NOP,  cond: C_ALWAYS,      target: STEP_WAIT};
        endcase
        return w;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] c;
        if (d < TEN) begin
            c = ZERO_CHAR + CHAR_W'(d);
        end else begin
            c = (upper ? UPPER_A : LOWER_A) + CHAR_W'(d - TEN);
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/integer_to_radix_text.sv
`timescale 1ns / 1ps
// Top level: signed 64-bit integer to ASCII text in radix 2 to 36.
//
// Usage
//   Input request: i_value (signed) and i_radix, taken when i_valid and o_ready
//   are high. Radix 0..1 acts as 2, 37..63 as 36. -2^63 is saturated to -(2^63-1).
//   Output: the text, one ASCII character per transfer on o_character, most significant
//   first, '-' leading for negatives; o_last marks the final character.
//   APB register 0, bit 0: upper_case (reset 1) picks A-Z or a-z for digits >= 10.
// Timing
//   A microcoded sequencer runs one request at a time. Each digit takes one
//   8-bit-per-cycle restoring division plus a push to the digit stack.
//   Emission pops the digits one at a time through the read, emit and more
//   steps; o_ready returns only once the whole text has been emitted.
// Reset and stalls
//   Synchronous active-low reset returns the sequencer to the wait step,
//   empties the output register and sets upper_case. A stalled receiver
//   holds the output register; the sequencer waits at the sign or emit step.
module integer_to_radix_text (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input request channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [itrt_pkg::VALUE_W-1:0]  i_value,
    input  logic [itrt_pkg::RADIX_W-1:0]  i_radix,
    // Output character channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [itrt_pkg::CHAR_W-1:0]   o_character,
    output logic                          o_last,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import itrt_pkg::*;

    t_ctrl ctrl;
    t_stat stat;

    logic                r_upper;
    logic                r_neg;
    logic                r_out_valid;
    logic [CHAR_W-1:0]   r_out_char;
    logic                r_out_last;

    logic [VALUE_W-1:0]  mag;
    logic [RADIX_W-1:0]  radix_c;
    logic [DIGIT_W-1:0]  digit;
    logic [DIGIT_W-1:0]  rdata;
    logic [IDX_W-1:0]    count;
    logic                quot_nz;
    logic                div_more;
    logic                out_free;
    logic                reg_sel;

    // Config register; paddr[2] is the register index
    assign reg_sel = paddr[2];
    assign pready  = 1'b1;
    assign prdata  = (reg_sel == REG_UPPER_CASE) ? {31'b0, r_upper} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper <= 1'b1;
        end else if (psel && penable && pwrite && pready && reg_sel == REG_UPPER_CASE) begin
            r_upper <= pwdata[0];
        end
    end

    // Magnitude with saturation of the most negative value, radix clamp
    always_comb begin
        if (i_value == MOST_NEG) begin
            mag = SAT_MAG;
        end else if (i_value[VALUE_W-1]) begin
            mag = ~i_value + VALUE_W'(1);
        end else begin
            mag = i_value;
        end
        if (i_radix < RADIX_MIN) begin
            radix_c = RADIX_MIN;
        end else if (i_radix > RADIX_MAX) begin
            radix_c = RADIX_MAX;
        end else begin
            radix_c = i_radix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.load) begin
            r_neg <= i_value[VALUE_W-1];
        end
    end

    // Output register
    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.sign || ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.sign) begin
            r_out_char <= SIGN_CHAR;
            r_out_last <= 1'b0;
        end else if (ctrl.emit) begin
            r_out_char <= digit_char(rdata, r_upper);
            r_out_last <= (count == '0);
        end
    end

    assign stat = '{in_valid:    i_valid,
                    div_more:    div_more,
                    quot_nz:     quot_nz,
                    neg:         r_neg,
                    out_free:    out_free,
                    digits_left: (count != '0)};

    itrt_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    itrt_div_unit u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ctrl),
        .i_mag      (mag),
        .i_radix    (radix_c),
        .o_digit    (digit),
        .o_quot_nz  (quot_nz),
        .o_div_more (div_more)
    );

    itrt_digit_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_digit (digit),
        .o_rdata (rdata),
        .o_count (count)
    );

    assign o_ready     = ctrl.in_ready;
    assign o_valid     = r_out_valid;
    assign o_character = r_out_char;
    assign o_last      = r_out_last;

    // The sign always precedes at least one digit
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_char == SIGN_CHAR |-> !r_out_last)
        else $error("sign marked as last character");

    // A new request is only taken once the previous text has been fully queued
    a_ready_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !r_out_valid || r_out_last)
        else $error("input taken mid-text");

    a_single_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ctrl.sign && ctrl.emit))
        else $error("sign and digit loaded together");

endmodule

>>> hw/rtl/itrt_div_unit.sv
`timescale 1ns / 1ps
// Radix divider: restoring division, eight quotient bits per cycle.
module itrt_div_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  itrt_pkg::t_ctrl               i_ctrl,
    input  logic [itrt_pkg::VALUE_W-1:0]  i_mag,
    input  logic [itrt_pkg::RADIX_W-1:0]  i_radix,
    output logic [itrt_pkg::DIGIT_W-1:0]  o_digit,
    output logic                          o_quot_nz,
    output logic                          o_div_more
);
    import itrt_pkg::*;

    logic [VALUE_W-1:0]    r_quot, n_quot;
    logic [DIGIT_W-1:0]    r_rem, n_rem;
    logic [RADIX_W-1:0]    r_radix;
    logic [STEP_CNT_W-1:0] r_cnt;

    // Eight restoring steps; remainder stays below the radix, so 7 bits cover the trial
    always_comb begin
        logic [DIGIT_W:0] t;
        logic [DIGIT_W:0] diff;
        n_quot = r_quot;
        n_rem  = r_rem;
        for (int i = 0; i < BITS_PER_STEP; i++) begin
            t      = {n_rem, n_quot[VALUE_W-1]};
            diff   = t - {1'b0, r_radix};
            n_quot = {n_quot[VALUE_W-2:0], 1'b0};
            if (t >= {1'b0, r_radix}) begin
                n_rem     = diff[DIGIT_W-1:0];
                n_quot[0] = 1'b1;
            end else begin
                n_rem = t[DIGIT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctrl.div) begin
            r_cnt <= r_cnt + STEP_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_quot  <= i_mag;
            r_rem   <= '0;
            r_radix <= i_radix;
        end else if (i_ctrl.div) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end else if (i_ctrl.push) begin
            r_rem <= '0;
        end
    end

    assign o_digit    = r_rem;
    assign o_quot_nz  = (r_quot != '0);
    assign o_div_more = (r_cnt != '1);

endmodule

>>> hw/rtl/itrt_digit_mem.sv
`timescale 1ns / 1ps
// Digit stack: digits pushed low order first, popped high order first.
module itrt_digit_mem (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  itrt_pkg::t_ctrl               i_ctrl,
    input  logic [itrt_pkg::DIGIT_W-1:0]  i_digit,
    output logic [itrt_pkg::DIGIT_W-1:0]  o_rdata,
    output logic [itrt_pkg::IDX_W-1:0]    o_count
);
    import itrt_pkg::*;

    logic [DIGIT_W-1:0] r_mem [STACK_DEPTH];
    logic [DIGIT_W-1:0] r_rdata;
    logic [IDX_W-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctrl.load) begin
            r_count <= '0;
        end else if (i_ctrl.push) begin
            r_count <= r_count + IDX_W'(1);
        end else if (i_ctrl.read) begin
            r_count <= r_count - IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[r_count] <= i_digit;
        end
        if (i_ctrl.read) begin
            r_rdata <= r_mem[r_count - IDX_W'(1)];
        end
    end

    assign o_rdata = r_rdata;
    assign o_count = r_count;

    // 63-bit magnitude never needs more than 63 digits
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.push |-> r_count != '1)
        else $error("digit stack overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.read |-> r_count != '0)
        else $error("digit stack underflow");

    a_pop_after_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.push |=> !i_ctrl.read)
        else $error("read directly after push");

endmodule

>>> hw/rtl/itrt_sequencer.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, ROM lookup, branch and strobe decode.
module itrt_sequencer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  itrt_pkg::t_stat i_stat,
    output itrt_pkg::t_ctrl o_ctrl
);
    import itrt_pkg::*;

    logic [PC_W-1:0] r_pc, n_pc;
    t_uword          w;
    logic            take;

    always_comb begin
        w = ucode(r_pc);

        case (w.cond)
            C_NEVER:       take = 1'b0;
            C_ALWAYS:      take = 1'b1;
            C_NO_INPUT:    take = !i_stat.in_valid;
            C_DIV_MORE:    take = i_stat.div_more;
            C_QUOT_NZ:     take = i_stat.quot_nz;
            C_SIGN_WAIT:   take = i_stat.neg && !i_stat.out_free;
            C_OUT_BUSY:    take = !i_stat.out_free;
            C_DIGITS_LEFT: take = i_stat.digits_left;
            default:       take = 1'b1;
        endcase
        n_pc = take ? w.target : r_pc + PC_W'(1);

        o_ctrl          = '0;
        o_ctrl.in_ready = (w.op == OP_LOAD);
        o_ctrl.load     = (w.op == OP_LOAD) && i_stat.in_valid;
        o_ctrl.div      = (w.op == OP_DIV);
        o_ctrl.push     = (w.op == OP_PUSH);
        o_ctrl.sign     = (w.op == OP_SIGN) && i_stat.neg && i_stat.out_free;
        o_ctrl.read     = (w.op == OP_READ);
        o_ctrl.emit     = (w.op == OP_EMIT) && i_stat.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

>>> tb/sv/integer_to_radix_text_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for integer_to_radix_text: predicts and checks each character.
module integer_to_radix_text_tb;

    import itrt_pkg::*;

    // Register map: upper_case is register 0, so it sits at byte address 0.
    localparam logic [2:0] UPPER_CASE_ADDR = 3'd0;

    // Character codes the conversion can produce.
    localparam logic [CHAR_W-1:0] MINUS_SIGN   = 8'h2D;
    localparam logic [CHAR_W-1:0] DIGIT_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] LETTER_UPPER = 8'h41;
    localparam logic [CHAR_W-1:0] LETTER_LOWER = 8'h61;

    // Radix limits and value extremes.
    localparam int BASE_LOW  = 2;
    localparam int BASE_HIGH = 36;
    localparam logic [VALUE_W-1:0] MIN_VALUE = 64'h8000_0000_0000_0000;
    localparam logic [VALUE_W-1:0] MAX_VALUE = 64'h7FFF_FFFF_FFFF_FFFF;

    // Stimulus shape and timing bounds.
    localparam int RANDOM_PHASES  = 4;
    localparam int PHASE_ITEMS    = 113;
    localparam int MAX_GAP        = 10;
    localparam int MAX_STALL      = 6;
    localparam int MAX_TEXT       = 64;
    localparam int SETTLE_CYCLES  = 8;
    // Worst case per request: 64 characters, each with its conversion work plus the
    // longest receiver stall, plus sender gap; summed over 480 requests, four times over.
    localparam int CYCLE_LIMIT    = 480 * (MAX_TEXT * (12 + MAX_STALL + 1) + MAX_GAP + 32) * 4;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_text_char;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_SLOW} t_rx_mode;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Request channel
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [VALUE_W-1:0] i_value = '0;
    logic [RADIX_W-1:0] i_radix = '0;

    // Character channel
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [CHAR_W-1:0] o_character;
    logic              o_last;

    // APB port
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // Shadow of the upper_case register, as reset leaves it.
    bit upper_case_cfg = 1'b1;

    // Characters still owed by the block, oldest first.
    t_text_char expected_text[$];

    int errors      = 0;
    int cycle_count = 0;
    int burst_left  = 0;

    // Receiver stall generator state
    t_rx_mode stall_mode = RX_ALWAYS;
    int       mode_left  = 0;
    int       low_run    = 0;

    integer_to_radix_text u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .i_radix     (i_radix),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_last      (o_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #4 i_clk = ~i_clk;

    // Converts one request to its text and queues the characters it owes:
    // clamp the radix, take the magnitude (most negative value saturates),
    // peel digits least significant first, then emit sign and digits in
    // reverse with last on the final one.
    function automatic void queue_radix_text(input logic [VALUE_W-1:0] value,
                                             input logic [RADIX_W-1:0] radix,
                                             input bit upper);
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] base;
        logic [VALUE_W-1:0] digit;
        logic [CHAR_W-1:0]  digits [0:MAX_TEXT-1];
        int                 count;
        t_text_char         tc;
        base = VALUE_W'(radix);
        if (base < VALUE_W'(BASE_LOW)) base = VALUE_W'(BASE_LOW);
        if (base > VALUE_W'(BASE_HIGH)) base = VALUE_W'(BASE_HIGH);
        if (value == MIN_VALUE) begin
            mag = MAX_VALUE;
        end else if (value[VALUE_W-1]) begin
            mag = ~value + VALUE_W'(1);
        end else begin
            mag = value;
        end
        count = 0;
        do begin
            digit = mag % base;
            if (digit < VALUE_W'(10)) begin
                digits[count] = DIGIT_ZERO + CHAR_W'(digit);
            end else begin
                digits[count] = (upper ? LETTER_UPPER : LETTER_LOWER) + CHAR_W'(digit - 10);
            end
            count++;
            mag = mag / base;
        end while (mag != 0 && count < MAX_TEXT);
        if (value[VALUE_W-1]) begin
            tc.code = MINUS_SIGN;
            tc.last = 1'b0;
            expected_text.push_back(tc);
        end
        for (int k = count - 1; k >= 0; k--) begin
            tc.code = digits[k];
            tc.last = (k == 0);
            expected_text.push_back(tc);
        end
    endfunction

    // Predicts on each accepted request, then checks each accepted character.
    // A request can't produce a character in the cycle it is taken, so the
    // order of the two steps inside one edge doesn't matter.
    always @(posedge i_clk) begin : check_text
        t_text_char want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                queue_radix_text(i_value, i_radix, upper_case_cfg);
            end
            if (o_valid && i_ready) begin
                if (expected_text.size() == 0) begin
                    $display("%0t: unexpected character: expected none actual %h last %b",
                             $time, o_character, o_last);
                    errors++;
                end else begin
                    want = expected_text.pop_front();
                    if (o_character !== want.code) begin
                        $display("%0t: character mismatch: expected %h actual %h",
                                 $time, want.code, o_character);
                        errors++;
                    end
                    if (o_last !== want.last) begin
                        $display("%0t: last mismatch: expected %b actual %b",
                                 $time, want.last, o_last);
                        errors++;
                    end
                end
            end
        end
    end

    // Receiver back-pressure: switches between always ready, coin flip, a
    // fixed one-in-four stall and mostly stalled; a stall run is capped at
    // MAX_STALL.
    always @(posedge i_clk) begin : ready_pattern
        bit go;
        if (mode_left == 0) begin
            stall_mode = t_rx_mode'($urandom_range(RX_ALWAYS, RX_SLOW));
            mode_left  = $urandom_range(50, 400);
        end
        mode_left--;
        case (stall_mode)
            RX_ALWAYS:   go = 1'b1;
            RX_COIN:     go = 1'($urandom_range(0, 1));
            RX_PERIODIC: go = (mode_left % 4) != 0;
            default:     go = ($urandom_range(0, 3) == 0);
        endcase
        if (!go && low_run >= MAX_STALL) go = 1'b1;
        low_run = go ? 0 : low_run + 1;
        i_ready <= go;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("integer_to_radix_text test failed");
            $finish;
        end
    end

    task automatic apply_reset();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // Offers one request and returns at the edge that takes it. Valid stays
    // high afterwards; the next send or idle_sender decides what follows.
    // Requests come in bursts; a new burst may start after a random gap.
    task automatic send_request(input logic [VALUE_W-1:0] value,
                                input logic [RADIX_W-1:0] radix);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_value <= value;
        i_radix <= radix;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic idle_sender();
        i_valid    <= 1'b0;
        burst_left = 0;
    endtask

    // Stops sending and waits until every owed character has come, then lets
    // the sequencer step back to its wait state.
    task automatic wait_for_text_drained();
        idle_sender();
        @(posedge i_clk);
        while (expected_text.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup then access cycle; the register takes the value at the end of the access cycle.
    // Bits above bit 0 carry noise, which the register ignores. A read
    // transfer follows and checks the value the register returns.
    task automatic write_upper_case(input bit upper);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= UPPER_CASE_ADDR;
        pwdata  <= {31'($urandom), upper};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (pready !== 1'b1 || prdata !== {31'b0, upper}) begin
            $display("%0t: upper_case read mismatch: expected %h actual %h",
                     $time, {31'b0, upper}, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        upper_case_cfg = upper;
    endtask

    // Magnitudes mostly small or of random width so that long binary texts
    // stay rare; a share of full 64-bit and corner values.
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        int                 pick;
        int                 width;
        pick = $urandom_range(0, 99);
        v = {$urandom, $urandom};
        if (pick < 30) begin
            v = VALUE_W'($urandom_range(0, 999));
        end else if (pick < 65) begin
            width = $urandom_range(1, VALUE_W);
            v = v >> (VALUE_W - width);
        end else if (pick >= 85) begin
            case ($urandom_range(0, 5))
                0:       v = MIN_VALUE;
                1:       v = MAX_VALUE;
                2:       v = MIN_VALUE + VALUE_W'(1);
                3:       v = '0;
                4:       v = VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
                default: v = (VALUE_W'(1) << $urandom_range(1, VALUE_W - 1)) - VALUE_W'(1);
            endcase
        end
        if (pick < 65 && $urandom_range(0, 1)) v = -v;
        return v;
    endfunction

    // Mostly legal radices; the rest spans the whole field to hit clamping.
    function automatic logic [RADIX_W-1:0] pick_radix();
        if ($urandom_range(0, 99) < 85) begin
            return RADIX_W'($urandom_range(BASE_LOW, BASE_HIGH));
        end
        return RADIX_W'($urandom_range(0, (1 << RADIX_W) - 1));
    endfunction

    // Letters and basics with the register as reset leaves it (upper case).
    task automatic test_default_case();
        send_request(64'd35, 6'd36);
        send_request(64'd0, 6'd10);
        send_request(-64'sd1, 6'd2);
        send_request(64'd255, 6'd16);
    endtask

    // Radix 0 and 1 act as 2; 37 and up act as 36.
    task automatic test_radix_clamp();
        send_request(64'd10, 6'd0);
        send_request(64'd10, 6'd1);
        send_request(64'd35, 6'd37);
        send_request(64'd35, 6'd63);
        send_request(-64'sd36, 6'd36);
    endtask

    // Full-length texts, the saturated most negative value and small ones.
    task automatic test_value_extremes();
        send_request(MIN_VALUE, 6'd2);
        send_request(MAX_VALUE, 6'd2);
        send_request(MIN_VALUE + VALUE_W'(1), 6'd10);
        send_request(MAX_VALUE, 6'd36);
        send_request(MIN_VALUE, 6'd16);
        send_request(64'd1, 6'd10);
    endtask

    // Lower-case letters, then back to the reset setting.
    task automatic test_lower_case();
        wait_for_text_drained();
        write_upper_case(1'b0);
        send_request(64'd35, 6'd36);
        send_request(-64'sd11259375, 6'd16);
        send_request(MIN_VALUE, 6'd36);
        wait_for_text_drained();
        write_upper_case(1'b1);
    endtask

    // Random requests in phases that alternate the letter case; each phase
    // starts from an idle block, and now and then the sender drains mid-phase.
    task automatic test_random_mix();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_for_text_drained();
            write_upper_case(phase[0]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 59) == 0) wait_for_text_drained();
                send_request(pick_value(), pick_radix());
            end
        end
    endtask

    initial begin
        apply_reset();
        test_default_case();
        test_radix_clamp();
        test_value_extremes();
        test_lower_case();
        test_random_mix();
        wait_for_text_drained();
        if (errors == 0) begin
            $display("integer_to_radix_text test passed");
        end else begin
            $display("integer_to_radix_text test failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/itrt_pkg.sv
hw/rtl/itrt_div_unit.sv
hw/rtl/itrt_digit_mem.sv
hw/rtl/itrt_sequencer.sv
hw/rtl/integer_to_radix_text.sv
tb/sv/integer_to_radix_text_tb.sv
